FILE: hdl/pei_pkg.sv
// Shared types, widths, opcodes and the Q16.16 saturation helper for the
// polynomial evaluate/integrate unit. No dependencies.
package pei_pkg;

    localparam int DATA_W         = 32;
    localparam int FRAC_W         = 16;
    localparam int PROD_W         = 2 * DATA_W - FRAC_W;
    localparam int SUM_W          = PROD_W + 1;
    localparam int K_W            = 35;
    localparam int DEG_W          = 3;
    localparam int CFG_IDX_W      = 4;
    localparam int MAX_DEGREE_DEF = 7;

    typedef enum logic [1:0] {
        OP_EVAL  = 2'd0,
        OP_DERIV = 2'd1,
        OP_INTEG = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef logic signed [DATA_W-1:0] t_q;
    typedef logic signed [K_W-1:0]    t_coef_k;

    typedef struct packed {
        t_opcode opcode;
        t_q      point_a;
        t_q      point_b;
    } t_in_req;

    typedef struct packed {
        t_q               value;
        logic             overflow;
        logic [DEG_W-1:0] poly_degree;
        logic             all_zero;
    } t_out_rsp;

    typedef struct packed {
        logic [DEG_W-1:0] poly_degree;
        logic             all_zero;
    } t_poly_status;

    typedef struct packed {
        t_opcode opcode;
        t_q      point_a;
        t_q      point_b;
        t_q      acc_a;
        t_q      acc_b;
        logic    ovf_a;
        logic    ovf_b;
    } t_cell_bus;

    typedef struct packed {
        t_q   value;
        logic ovf;
    } t_sat;

    function automatic t_sat sat_q(input logic signed [SUM_W-1:0] v);
        t_sat r;
        if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
            r.value = v[DATA_W-1:0];
            r.ovf   = 1'b0;
        end else if (v[SUM_W-1]) begin
            r.value = {1'b1, {(DATA_W-1){1'b0}}};
            r.ovf   = 1'b1;
        end else begin
            r.value = {1'b0, {(DATA_W-1){1'b1}}};
            r.ovf   = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: hdl/pei_coef_bank.sv
// Coefficient registers plus derived derivative and antiderivative
// coefficient tables, and the degree / zero status. Uses pei_pkg.
module pei_coef_bank
    import pei_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    output t_coef_k              o_k_eval  [MAX_DEGREE+2],
    output t_coef_k              o_k_deriv [MAX_DEGREE+2],
    output t_coef_k              o_k_integ [MAX_DEGREE+2],
    output t_poly_status         o_status
);

    localparam int NUM_C = MAX_DEGREE + 1;
    localparam int NUM_K = MAX_DEGREE + 2;
    localparam int DIV_W = $clog2(NUM_C + 1);
    localparam int REM_W = DATA_W + DIV_W;

    t_q               r_coef [NUM_C];
    t_coef_k          mul_k  [NUM_C];
    t_coef_k          div_k  [NUM_C];
    logic [DEG_W-1:0] deg;
    logic             nonzero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_C; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            for (int i = 0; i < NUM_C; i++) begin
                if (i_cfg_index == CFG_IDX_W'(i)) begin
                    r_coef[i] <= i_cfg_data;
                end
            end
        end
    end

    for (genvar gi = 0; gi < NUM_C; gi++) begin : g_coef
        localparam logic [DATA_W-1:0] RECIP =
            DATA_W'(((64'd1 << DATA_W) - 64'd1) / 64'(gi + 1));
        localparam logic [REM_W-1:0]  DIVISOR = REM_W'(gi + 1);
        localparam t_coef_k           SCALE   = K_W'(gi);

        logic                  neg;
        logic [DATA_W-1:0]     mag;
        logic [2*DATA_W-1:0]   prod;
        logic [REM_W-1:0]      rem;
        logic [DATA_W-1:0]     quo;
        logic                  r_neg;
        logic [DATA_W-1:0]     r_mag;
        logic [DATA_W-1:0]     r_quo;
        t_coef_k               r_scaled;
        t_coef_k               r_mul;
        t_coef_k               r_div;

        assign neg  = r_coef[gi][DATA_W-1];
        assign mag  = neg ? ((~r_coef[gi]) + DATA_W'(1)) : r_coef[gi];
        assign prod = {{DATA_W{1'b0}}, mag} * {{DATA_W{1'b0}}, RECIP};
        assign rem  = REM_W'(r_mag) - (REM_W'(r_quo) * DIVISOR);
        assign quo  = r_quo + DATA_W'(rem >= DIVISOR);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_neg    <= 1'b0;
                r_mag    <= '0;
                r_quo    <= '0;
                r_scaled <= '0;
                r_mul    <= '0;
                r_div    <= '0;
            end else begin
                r_neg    <= neg;
                r_mag    <= mag;
                r_quo    <= prod[2*DATA_W-1:DATA_W];
                r_scaled <= t_coef_k'(r_coef[gi]) * SCALE;
                r_mul    <= r_scaled;
                r_div    <= r_neg ? -t_coef_k'(quo) : t_coef_k'(quo);
            end
        end

        assign mul_k[gi] = r_mul;
        assign div_k[gi] = r_div;
    end

    for (genvar gj = 0; gj < NUM_K; gj++) begin : g_k
        if (gj < NUM_C) begin : g_eval
            assign o_k_eval[gj] = t_coef_k'(r_coef[gj]);
        end else begin : g_eval_top
            assign o_k_eval[gj] = '0;
        end
        if (gj < MAX_DEGREE) begin : g_deriv
            assign o_k_deriv[gj] = mul_k[gj+1];
        end else begin : g_deriv_top
            assign o_k_deriv[gj] = '0;
        end
        if (gj == 0) begin : g_integ_low
            assign o_k_integ[gj] = '0;
        end else begin : g_integ
            assign o_k_integ[gj] = div_k[gj-1];
        end
    end

    always_comb begin
        deg     = '0;
        nonzero = 1'b0;
        for (int i = 0; i < NUM_C; i++) begin
            if (r_coef[i] != '0) begin
                deg     = DEG_W'(i);
                nonzero = 1'b1;
            end
        end
    end

    assign o_status.poly_degree = deg;
    assign o_status.all_zero    = !nonzero;

endmodule

FILE: hdl/pei_horner_cell.sv
// One Horner step on two lanes: multiply stage, then add-and-saturate stage,
// each with its own valid and backpressure. Uses pei_pkg.
module pei_horner_cell
    import pei_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_cell_bus i_bus,
    output logic      o_valid,
    input  logic      i_ready,
    output t_cell_bus o_bus,
    input  t_coef_k   i_k_eval,
    input  t_coef_k   i_k_deriv,
    input  t_coef_k   i_k_integ
);

    logic                       r_m_valid;
    logic                       r_s_valid;
    t_cell_bus                  r_m_bus;
    t_cell_bus                  r_s_bus;
    t_cell_bus                  n_s_bus;
    logic signed [PROD_W-1:0]   r_prod_a;
    logic signed [PROD_W-1:0]   r_prod_b;
    logic                       m_ready;
    logic                       s_ready;
    logic signed [2*DATA_W-1:0] prod_a;
    logic signed [2*DATA_W-1:0] prod_b;
    t_coef_k                    k_sel;
    t_sat                       sat_a;
    t_sat                       sat_b;

    assign s_ready = !r_s_valid || i_ready;
    assign m_ready = !r_m_valid || s_ready;
    assign o_ready = m_ready;

    assign prod_a = $signed(i_bus.acc_a) * $signed(i_bus.point_a);
    assign prod_b = $signed(i_bus.acc_b) * $signed(i_bus.point_b);

    always_comb begin
        case (r_m_bus.opcode)
            OP_EVAL:  k_sel = i_k_eval;
            OP_DERIV: k_sel = i_k_deriv;
            OP_INTEG: k_sel = i_k_integ;
            default:  k_sel = '0;
        endcase
        sat_a = sat_q(SUM_W'(r_prod_a) + SUM_W'(k_sel));
        sat_b = sat_q(SUM_W'(r_prod_b) + SUM_W'(k_sel));
        n_s_bus       = r_m_bus;
        n_s_bus.acc_a = sat_a.value;
        n_s_bus.acc_b = sat_b.value;
        n_s_bus.ovf_a = r_m_bus.ovf_a || sat_a.ovf;
        n_s_bus.ovf_b = r_m_bus.ovf_b || sat_b.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (m_ready) begin
                r_m_valid <= i_valid;
            end
            if (s_ready) begin
                r_s_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_ready && i_valid) begin
            r_m_bus  <= i_bus;
            r_prod_a <= prod_a[2*DATA_W-1:FRAC_W];
            r_prod_b <= prod_b[2*DATA_W-1:FRAC_W];
        end
        if (s_ready && r_m_valid) begin
            r_s_bus <= n_s_bus;
        end
    end

    assign o_valid = r_s_valid;
    assign o_bus   = r_s_bus;

endmodule

FILE: hdl/polynomial_evaluate_integrate_unit.sv
// Top level of the polynomial evaluate/integrate unit: input register, chain
// of Horner cells, final combine and output register. Uses pei_pkg,
// pei_coef_bank and pei_horner_cell.
//
// Evaluates a Q16.16 polynomial of up to MAX_DEGREE, its derivative, or its
// definite integral between point_a and point_b, one request per cycle while
// the output is not stalled. Each request walks a chain of MAX_DEGREE+2
// Horner cells, each cell being a 32x32 multiply stage and an add/saturate
// stage, with both bounds of an integral in parallel lanes. Stages have their
// own valid bits, so requests keep entering while a result waits at the
// output. The configuration port is always ready; derived derivative and
// integral coefficients settle through their own registers after a write,
// which the pipeline depth covers, so a request may follow a write in the
// next cycle.
module polynomial_evaluate_integrate_unit
    import pei_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_rsp             o_out_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int NUM_K = MAX_DEGREE + 2;

    t_coef_k      k_eval  [NUM_K];
    t_coef_k      k_deriv [NUM_K];
    t_coef_k      k_integ [NUM_K];
    t_poly_status status;
    logic         r_in_valid;
    t_in_req      r_in_req;
    logic         cell_valid [NUM_K+1];
    logic         cell_ready [NUM_K+1];
    t_cell_bus    cell_bus   [NUM_K+1];
    t_cell_bus    last;
    t_sat         sat_d;
    t_out_rsp     n_out_rsp;
    logic         r_out_valid;
    t_out_rsp     r_out_rsp;

    assign o_cfg_ready = 1'b1;

    pei_coef_bank #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_coef_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_k_eval    (k_eval),
        .o_k_deriv   (k_deriv),
        .o_k_integ   (k_integ),
        .o_status    (status)
    );

    assign o_in_ready = !r_in_valid || cell_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req <= i_in_req;
        end
    end

    assign cell_valid[0]       = r_in_valid;
    assign cell_bus[0].opcode  = r_in_req.opcode;
    assign cell_bus[0].point_a = r_in_req.point_a;
    assign cell_bus[0].point_b = r_in_req.point_b;
    assign cell_bus[0].acc_a   = '0;
    assign cell_bus[0].acc_b   = '0;
    assign cell_bus[0].ovf_a   = 1'b0;
    assign cell_bus[0].ovf_b   = 1'b0;

    for (genvar gc = 0; gc < NUM_K; gc++) begin : g_cell
        pei_horner_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (cell_valid[gc]),
            .o_ready   (cell_ready[gc]),
            .i_bus     (cell_bus[gc]),
            .o_valid   (cell_valid[gc+1]),
            .i_ready   (cell_ready[gc+1]),
            .o_bus     (cell_bus[gc+1]),
            .i_k_eval  (k_eval[NUM_K-1-gc]),
            .i_k_deriv (k_deriv[NUM_K-1-gc]),
            .i_k_integ (k_integ[NUM_K-1-gc])
        );
    end

    assign last              = cell_bus[NUM_K];
    assign cell_ready[NUM_K] = !r_out_valid || i_out_ready;

    always_comb begin
        sat_d = sat_q(SUM_W'($signed(last.acc_b)) - SUM_W'($signed(last.acc_a)));
        n_out_rsp.poly_degree = status.poly_degree;
        n_out_rsp.all_zero    = status.all_zero;
        case (last.opcode)
            OP_EVAL, OP_DERIV: begin
                n_out_rsp.value    = last.acc_a;
                n_out_rsp.overflow = last.ovf_a;
            end
            OP_INTEG: begin
                n_out_rsp.value    = sat_d.value;
                n_out_rsp.overflow = last.ovf_a || last.ovf_b || sat_d.ovf;
            end
            default: begin
                n_out_rsp.value    = '0;
                n_out_rsp.overflow = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cell_ready[NUM_K]) begin
            r_out_valid <= cell_valid[NUM_K];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_ready[NUM_K] && cell_valid[NUM_K]) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

FILE: hdl/pei_checker.sv
// Port-level checks for the polynomial evaluate/integrate unit, bound to the
// top level. Uses pei_pkg.
module pei_checker
    import pei_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_rsp o_out_rsp
);

    localparam int CNT_W = 8;

    logic [CNT_W-1:0] r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + CNT_W'(i_in_valid && o_in_ready)
                                   - CNT_W'(o_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("result request dropped or changed while stalled");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.all_zero |->
            o_out_rsp.value == '0 && !o_out_rsp.overflow)
        else $error("zero polynomial gave nonzero value or overflow");

    a_zero_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.all_zero |-> o_out_rsp.poly_degree == '0)
        else $error("zero polynomial reported nonzero degree");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != '0)
        else $error("result request without an accepted input request");

endmodule

bind polynomial_evaluate_integrate_unit pei_checker u_pei_checker (.*);

FILE: bench/tb.sv
// Self-checking bench for polynomial_evaluate_integrate_unit: random and directed
// Q16.16 requests under random back-pressure, checked against an in-bench predictor.
// Depends on pei_pkg and the unit's RTL.
module tb;
    import pei_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEG_MAX       = MAX_DEGREE_DEF;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 2 * (2 * DEG_MAX + 6);
    localparam int LONG_HOLD     = 300;
    localparam int CFG_IDX_TOP   = (1 << CFG_IDX_W) - 1;
    localparam t_q Q_MAX         = 32'h7FFF_FFFF;
    localparam t_q Q_MIN         = 32'h8000_0000;
    localparam t_q Q_ONE         = 32'h0001_0000;

    typedef enum int {
        CFG_SMALL,
        CFG_FULL,
        CFG_EXTREME,
        CFG_SPARSE
    } coef_style_e;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    t_in_req              in_req     = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    t_out_rsp             out_rsp;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [DATA_W-1:0]    cfg_data   = '0;

    longint   coef_model [0:DEG_MAX];
    t_in_req  pending_req [$];
    t_out_rsp expected_rsp [$];
    int       n_queued         = 0;
    int       n_checked        = 0;
    int       n_fail           = 0;
    int       send_gap         = 0;
    int       hold_left        = 0;
    int       idle_cycles      = 0;
    bit       no_idle          = 1'b0;
    bit       long_stall_req   = 1'b0;
    bit       long_stall_taken = 1'b0;

    polynomial_evaluate_integrate_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic longint clamp_q(input longint v, inout bit ovf);
        if (v > longint'(Q_MAX)) begin
            ovf = 1'b1;
            return longint'(Q_MAX);
        end
        if (v < longint'(Q_MIN)) begin
            ovf = 1'b1;
            return longint'(Q_MIN);
        end
        return v;
    endfunction

    function automatic longint horner_stage(input longint acc, input longint x,
                                            input longint kk, inout bit ovf);
        return clamp_q(((acc * x) >>> FRAC_W) + kk, ovf);
    endfunction

    function automatic longint poly_at(input longint x, inout bit ovf);
        longint acc;
        int     i;
        acc = 0;
        for (i = DEG_MAX; i >= 0; i--)
            acc = horner_stage(acc, x, coef_model[i], ovf);
        return acc;
    endfunction

    function automatic longint slope_at(input longint x, inout bit ovf);
        longint acc;
        int     i;
        acc = 0;
        for (i = DEG_MAX; i >= 1; i--)
            acc = horner_stage(acc, x, coef_model[i] * i, ovf);
        return acc;
    endfunction

    function automatic longint area_to(input longint x, inout bit ovf);
        longint acc;
        longint kk;
        int     j;
        acc = 0;
        for (j = DEG_MAX + 1; j >= 0; j--) begin
            kk  = (j == 0) ? 64'sd0 : coef_model[j-1] / j;
            acc = horner_stage(acc, x, kk, ovf);
        end
        return acc;
    endfunction

    function automatic t_out_rsp predict_rsp(input t_in_req req);
        t_out_rsp rsp;
        bit       ovf;
        longint   val;
        longint   fa;
        longint   fb;
        int       top;
        int       i;
        ovf = 1'b0;
        val = 0;
        top = 0;
        for (i = DEG_MAX; i >= 1; i--)
            if (top == 0 && coef_model[i] != 0)
                top = i;
        case (req.opcode)
            OP_EVAL:  val = poly_at(longint'(req.point_a), ovf);
            OP_DERIV: val = slope_at(longint'(req.point_a), ovf);
            OP_INTEG: begin
                fb  = area_to(longint'(req.point_b), ovf);
                fa  = area_to(longint'(req.point_a), ovf);
                val = clamp_q(fb - fa, ovf);
            end
            default:  val = 0;
        endcase
        rsp.value       = t_q'(val);
        rsp.overflow    = ovf;
        rsp.poly_degree = top[DEG_W-1:0];
        rsp.all_zero    = (top == 0 && coef_model[0] == 0);
        return rsp;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_q extreme_val();
        case ($urandom_range(0, 6))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3:       return Q_ONE;
            4:       return -Q_ONE;
            5:       return 32'sd1;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic t_q small_val(input int bits);
        return t_q'(int'($urandom_range(0, 2 ** (bits + 1))) - (2 ** bits));
    endfunction

    function automatic t_q rand_point();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return extreme_val();
        if (r < 5)  return small_val(17);
        return t_q'($urandom);
    endfunction

    function automatic t_opcode rand_op();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3) return OP_EVAL;
        if (r < 6) return OP_DERIV;
        if (r < 9) return OP_INTEG;
        return OP_NONE;
    endfunction

    function automatic void note_fail(input string what);
        n_fail++;
        if (n_fail <= 10)
            $display("%s", what);
    endfunction

    // request driver: one valid update per edge, refilled from the pending queue
    always @(posedge clk) begin : drive_req
        logic nxt_valid;
        nxt_valid = in_valid;
        if (!rst_n) begin
            nxt_valid = 1'b0;
            send_gap  = 0;
        end else begin
            if (in_valid && in_ready) begin
                expected_rsp.push_back(predict_rsp(in_req));
                nxt_valid = 1'b0;
                send_gap  = no_idle ? 0 : pick_gap();
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_req.size() > 0) begin
                    in_req    <= pending_req.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        in_valid <= nxt_valid;
    end

    always @(posedge clk) begin : drive_ready
        int g;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (long_stall_req && !long_stall_taken) begin
            long_stall_taken = 1'b1;
            hold_left        = LONG_HOLD - 1;
            out_ready        <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            g = (!no_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (g > 0) begin
                hold_left = g - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : check_rsp
        t_out_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_rsp.size() == 0) begin
                note_fail($sformatf("unexpected result: value %h ovf %b deg %0d zero %b",
                    out_rsp.value, out_rsp.overflow, out_rsp.poly_degree, out_rsp.all_zero));
            end else begin
                want = expected_rsp.pop_front();
                n_checked++;
                if (out_rsp.value !== want.value || out_rsp.overflow !== want.overflow
                    || out_rsp.poly_degree !== want.poly_degree
                    || out_rsp.all_zero !== want.all_zero)
                    note_fail($sformatf(
                        "mismatch: exp value %h ovf %b deg %0d zero %b, got value %h ovf %b deg %0d zero %b",
                        want.value, want.overflow, want.poly_degree, want.all_zero,
                        out_rsp.value, out_rsp.overflow, out_rsp.poly_degree, out_rsp.all_zero));
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_coef(input int idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx <= DEG_MAX)
            coef_model[idx] = longint'($signed(data));
    endtask

    task automatic load_coefs(input coef_style_e style);
        int         top;
        int         i;
        bit         blank;
        t_q         c;
        top   = $urandom_range(0, DEG_MAX);
        blank = ($urandom_range(0, 3) == 0);
        for (i = 0; i <= DEG_MAX; i++) begin
            case (style)
                CFG_SMALL:   c = small_val(18);
                CFG_FULL:    c = t_q'($urandom);
                CFG_EXTREME: c = extreme_val();
                default: begin
                    if (blank || i > top) begin
                        c = '0;
                    end else begin
                        c = small_val(20);
                        if (i == top && c == 0)
                            c = Q_ONE;
                        else if (i < top && $urandom_range(0, 1) == 1)
                            c = '0;
                    end
                end
            endcase
            write_coef(i, c);
        end
        if ($urandom_range(0, 2) == 0)
            write_coef($urandom_range(DEG_MAX + 1, CFG_IDX_TOP), $urandom);
    endtask

    task automatic fill_coefs(input t_q c);
        int i;
        for (i = 0; i <= DEG_MAX; i++)
            write_coef(i, c);
    endtask

    task automatic queue_req(input t_opcode op, input t_q a, input t_q b);
        t_in_req r;
        r.opcode  = op;
        r.point_a = a;
        r.point_b = b;
        pending_req.push_back(r);
        n_queued++;
    endtask

    task automatic drain();
        while (n_checked != n_queued) @(posedge clk);
    endtask

    initial begin : stimulus
        int p;
        int n;
        int i;
        for (i = 0; i <= DEG_MAX; i++)
            coef_model[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: zero polynomial
        queue_req(OP_EVAL, Q_ONE, t_q'($urandom));
        queue_req(OP_DERIV, Q_MAX, '0);
        queue_req(OP_INTEG, Q_MIN, Q_MAX);
        queue_req(OP_NONE, t_q'($urandom), t_q'($urandom));
        drain();

        for (i = 0; i <= DEG_MAX; i++)
            write_coef(i, (i % 2 == 1) ? -((i + 1) * 32768) : (i + 1) * 32768);
        write_coef(DEG_MAX + 1, '1);
        write_coef(CFG_IDX_TOP, $urandom);
        queue_req(OP_EVAL, '0, t_q'($urandom));
        queue_req(OP_EVAL, Q_ONE, t_q'($urandom));
        queue_req(OP_EVAL, -Q_ONE, t_q'($urandom));
        queue_req(OP_EVAL, Q_MAX, t_q'($urandom));
        queue_req(OP_EVAL, Q_MIN, t_q'($urandom));
        queue_req(OP_DERIV, Q_ONE, t_q'($urandom));
        queue_req(OP_DERIV, -Q_ONE, t_q'($urandom));
        queue_req(OP_DERIV, Q_MAX, t_q'($urandom));
        queue_req(OP_DERIV, Q_MIN, t_q'($urandom));
        queue_req(OP_INTEG, '0, Q_ONE);
        queue_req(OP_INTEG, -Q_ONE, Q_ONE);
        queue_req(OP_INTEG, Q_MIN, Q_MAX);
        queue_req(OP_INTEG, Q_MAX, Q_MIN);
        queue_req(OP_NONE, t_q'($urandom), t_q'($urandom));
        drain();

        // clamp in an upper stage, later stages pull the value back in range
        fill_coefs('0);
        write_coef(DEG_MAX, Q_MAX);
        write_coef(DEG_MAX - 1, Q_MAX);
        write_coef(DEG_MAX - 2, Q_MIN);
        queue_req(OP_EVAL, Q_ONE, '0);
        queue_req(OP_DERIV, Q_ONE, '0);
        queue_req(OP_INTEG, '0, Q_ONE);
        drain();

        fill_coefs(Q_MAX);
        queue_req(OP_EVAL, Q_ONE, '0);
        queue_req(OP_INTEG, Q_MIN, Q_MAX);
        drain();

        fill_coefs(Q_MIN);
        queue_req(OP_EVAL, -Q_ONE, '0);
        queue_req(OP_DERIV, Q_MAX, '0);
        drain();

        for (p = 0; p < 12; p++) begin
            load_coefs(coef_style_e'(p % 4));
            no_idle = (p % 5 == 2) || (p == 1);
            if (p == 1)
                long_stall_req = 1'b1;
            for (n = 0; n < 165; n++)
                queue_req(rand_op(), rand_point(), rand_point());
            drain();
        end
        no_idle = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_rsp.size() != 0)
            note_fail($sformatf("%0d results never arrived", expected_rsp.size()));
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
